// ===== sv/tif_pkg.sv =====
package tif_pkg;

	localparam logic [7:0] IAC_CODE   = 8'hFF;
	localparam logic [7:0] AYT_CODE   = 8'hF6;
	localparam logic [7:0] WILL_CODE  = 8'hFB;
	localparam logic [7:0] WONT_CODE  = 8'hFC;
	localparam logic [7:0] DO_CODE    = 8'hFD;
	localparam logic [7:0] OPT_BINARY = 8'h00;
	localparam logic [7:0] CTRL_D     = 8'h04;
	localparam logic [7:0] CTRL_F     = 8'h06;
	localparam logic [7:0] ASCII_MAX  = 8'h7F;

	localparam logic [7:0] INT_CHAR_RESET = 8'h03;
	localparam logic       INT_EN_RESET   = 1'b1;

	localparam int MAX_RESULTS    = 3;
	localparam int RES_FIFO_DEPTH = 8;

	typedef enum logic [1:0] {
		OK_NONE  = 2'd0,
		OK_DATA  = 2'd1,
		OK_REPLY = 2'd2
	} out_kind_t;

	typedef enum logic [1:0] {
		PH_DATA = 2'd0,
		PH_IAC  = 2'd1,
		PH_VERB = 2'd2
	} phase_t;

	typedef enum logic {
		REG_INT_CHAR = 1'b0,
		REG_INT_EN   = 1'b1
	} cfg_reg_t;

	typedef struct packed {
		out_kind_t   kind;
		logic [7:0]  data;
		logic        ki;
		logic        sb;
		logic        last;
	} result_t;

endpackage

// ===== sv/telnet_iac_input_filter_core.sv =====
// Telnet receive filter: strips IAC command sequences from the received byte
// stream, answers IAC AYT and option-0 negotiation with reply bytes, tracks
// binary mode, and filters data bytes for the host (interrupt character,
// Ctrl-F safe-boot request, NUL and 8-bit bytes outside binary mode). One
// item is taken per cycle unless stalled; it is decoded from its input
// register and its zero to three results are pushed into a result queue of
// FifoDepth entries, drained at one result per cycle while result_stall is low.
// The input stalls while the decode stage holds an item and the queue has
// fewer than three free entries, so sustained rate is one item per cycle
// as long as items produce on average at most one result each. A new-session
// item (kind 1) clears the parse state and binary mode and produces no result.
// Configuration writes are always taken (cfg_ready is tied high).
module telnet_iac_input_filter_core import tif_pkg::*; #(
	parameter int FifoDepth = RES_FIFO_DEPTH
) (
	input  logic        clk,
	input  logic        arst_n,

	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic        cfg_index,
	input  logic [7:0]  cfg_data,

	input  logic        item_valid,
	output logic        item_stall,
	input  logic        kind,
	input  logic [7:0]  in_byte,
	input  logic        logged_in,

	output logic        result_valid,
	input  logic        result_stall,
	output logic [1:0]  out_kind,
	output logic [7:0]  out_byte,
	output logic        keyboard_interrupt,
	output logic        safe_boot_request,
	output logic        last
);

	localparam int PtrW = $clog2(FifoDepth);
	localparam int CntW = $clog2(FifoDepth + 1);
	localparam int SumW = PtrW + 1;

	logic [7:0]       int_char_q;
	logic             int_en_q;

	logic             valid_s1;
	logic             kind_s1;
	logic [7:0]       byte_s1;
	logic             logged_s1;

	phase_t           phase_q;
	logic [7:0]       held_verb_q;
	logic             binary_q;

	phase_t           phase_d;
	logic [7:0]       held_verb_d;
	logic             binary_d;
	result_t          res [MAX_RESULTS];
	logic [1:0]       n_res;

	result_t          fifo_q [FifoDepth];
	logic [PtrW-1:0]  wr_q;
	logic [PtrW-1:0]  rd_q;
	logic [CntW-1:0]  count_q;
	logic [PtrW-1:0]  wr_idx [MAX_RESULTS];
	logic [PtrW-1:0]  wr_next;
	logic [PtrW-1:0]  rd_next;

	logic             accept;
	logic             go_s1;
	logic             pop;
	logic [CntW-1:0]  push_cnt;
	result_t          head;

	function automatic logic [PtrW-1:0] ptr_add(logic [PtrW-1:0] p, logic [1:0] k);
		logic [SumW-1:0] s;
		s = {1'b0, p} + SumW'(k);
		if (s >= SumW'(FifoDepth))
			s = s - SumW'(FifoDepth);
		return s[PtrW-1:0];
	endfunction

	// configuration
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			int_char_q <= INT_CHAR_RESET;
			int_en_q   <= INT_EN_RESET;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_INT_CHAR: int_char_q <= cfg_data;
				REG_INT_EN:   int_en_q   <= cfg_data[0];
				default:      ;
			endcase
		end
	end

	// input register
	assign go_s1      = valid_s1 && (count_q <= CntW'(FifoDepth - MAX_RESULTS));
	assign item_stall = valid_s1 && !go_s1;
	assign accept     = item_valid && !item_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (accept)
			valid_s1 <= 1'b1;
		else if (go_s1)
			valid_s1 <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			kind_s1   <= kind;
			byte_s1   <= in_byte;
			logged_s1 <= logged_in;
		end
	end

	// decode
	always_comb begin
		logic is_int;
		logic drop;
		logic [7:0] reply;
		phase_d     = phase_q;
		held_verb_d = held_verb_q;
		binary_d    = binary_q;
		n_res       = 2'd0;
		is_int      = int_en_q && (byte_s1 == int_char_q);
		drop        = 1'b0;
		reply       = (held_verb_q < DO_CODE) ? held_verb_q + 8'd2 : held_verb_q - 8'd2;
		for (int i = 0; i < MAX_RESULTS; i++)
			res[i] = '{kind: OK_NONE, data: 8'h00, ki: 1'b0, sb: 1'b0, last: 1'b0};

		if (kind_s1) begin
			phase_d     = PH_DATA;
			held_verb_d = 8'h00;
			binary_d    = 1'b0;
		end else begin
			unique case (phase_q)
				PH_IAC: begin
					if (byte_s1 == IAC_CODE) begin
						phase_d = PH_DATA;
						n_res   = 2'd1;
						res[0]  = '{kind: OK_DATA, data: IAC_CODE, ki: 1'b0, sb: 1'b0,
							last: 1'b0};
					end else if (byte_s1 == AYT_CODE) begin
						phase_d = PH_DATA;
						if (logged_s1) begin
							n_res  = 2'd2;
							res[0] = '{kind: OK_REPLY, data: IAC_CODE, ki: 1'b0, sb: 1'b0,
								last: 1'b0};
							res[1] = '{kind: OK_REPLY, data: AYT_CODE, ki: 1'b0, sb: 1'b0,
								last: 1'b0};
						end
					end else begin
						held_verb_d = byte_s1;
						phase_d     = PH_VERB;
					end
				end
				PH_VERB: begin
					phase_d = PH_DATA;
					if (byte_s1 == OPT_BINARY) begin
						if (held_verb_q == WILL_CODE)
							binary_d = 1'b1;
						if (held_verb_q == WONT_CODE)
							binary_d = 1'b0;
						if (logged_s1) begin
							n_res  = 2'd3;
							res[0] = '{kind: OK_REPLY, data: IAC_CODE, ki: 1'b0, sb: 1'b0,
								last: 1'b0};
							res[1] = '{kind: OK_REPLY, data: reply, ki: 1'b0, sb: 1'b0,
								last: 1'b0};
							res[2] = '{kind: OK_REPLY, data: OPT_BINARY, ki: 1'b0, sb: 1'b0,
								last: 1'b0};
						end
					end
				end
				default: begin
					phase_d = PH_DATA;
					if (byte_s1 == IAC_CODE) begin
						phase_d = PH_IAC;
					end else if (binary_q) begin
						n_res  = 2'd1;
						res[0] = '{kind: OK_DATA, data: byte_s1, ki: 1'b0, sb: 1'b0,
							last: 1'b0};
					end else begin
						drop = (byte_s1 > ASCII_MAX) || (byte_s1 == 8'h00) ||
							(logged_s1 && (is_int || byte_s1 == CTRL_F));
						if (!drop) begin
							n_res  = 2'd1;
							res[0] = '{kind: OK_DATA, data: byte_s1, ki: 1'b0, sb: 1'b0,
								last: 1'b0};
						end else if (is_int) begin
							n_res  = 2'd1;
							res[0] = '{kind: OK_NONE, data: 8'h00, ki: 1'b1, sb: 1'b0,
								last: 1'b0};
						end else if (byte_s1 == CTRL_F) begin
							n_res  = 2'd1;
							res[0] = '{kind: OK_DATA, data: CTRL_D, ki: 1'b0, sb: 1'b1,
								last: 1'b0};
						end
					end
				end
			endcase
		end

		for (int i = 0; i < MAX_RESULTS; i++)
			res[i].last = (2'(i) == n_res - 2'd1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_DATA;
			held_verb_q <= 8'h00;
			binary_q    <= 1'b0;
		end else if (go_s1) begin
			phase_q     <= phase_d;
			held_verb_q <= held_verb_d;
			binary_q    <= binary_d;
		end
	end

	// result queue
	always_comb begin
		for (int i = 0; i < MAX_RESULTS; i++)
			wr_idx[i] = ptr_add(wr_q, 2'(i));
	end

	assign wr_next  = ptr_add(wr_q, n_res);
	assign rd_next  = ptr_add(rd_q, 2'd1);
	assign push_cnt = go_s1 ? CntW'(n_res) : '0;
	assign pop      = result_valid && !result_stall;

	always_ff @(posedge clk) begin
		for (int i = 0; i < MAX_RESULTS; i++) begin
			if (go_s1 && (2'(i) < n_res))
				fifo_q[wr_idx[i]] <= res[i];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			if (go_s1)
				wr_q <= wr_next;
			if (pop)
				rd_q <= rd_next;
			count_q <= count_q + push_cnt - CntW'(pop);
		end
	end

	assign head               = fifo_q[rd_q];
	assign result_valid       = (count_q != '0);
	assign out_kind           = head.kind;
	assign out_byte           = head.data;
	assign keyboard_interrupt = head.ki;
	assign safe_boot_request  = head.sb;
	assign last               = head.last;

endmodule
